/* src/tna_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle normal and area: shared constants
// Fixed output formats and arithmetic building-block sizes used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package tna_pkg;

  // The cross product length is in Q.32; the area is half of it in Q.16.
  localparam int unsigned AreaShift   = 17;
  localparam int unsigned AreaWidth   = 63;
  localparam int unsigned NormalWidth = 32;

  // Width of one partial-product slice in the pipelined multipliers.
  localparam int unsigned MulChunk    = 24;

endpackage

`default_nettype wire

/* src/triangle_normal_and_area_core.sv */
// ----------------------------------------------------------------------------
// Triangle normal and area core
// Unit face normal and area of a triangle given by three Q16.16 vertices.
// ----------------------------------------------------------------------------
// The block is used like a queue on both sides. A triangle beat is written
// with push while full is low; the result beat sits on the result ports while
// empty is low and is removed with pop.
//
// A front end forms the edges, their cross product and its squared length
// and writes into a sixteen-entry queue. A back end takes a square root, one
// result bit per stage, then three restoring divisions, one bit per stage.
// One triangle is accepted per cycle for as long as results are taken.
//
// When the receiver stalls, the back end holds its pipeline while the front
// end keeps running into the queue; full rises once all queue slots are
// spoken for by triangles already accepted. Reset empties every pipeline and
// the queue and clears the credit count; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_normal_and_area_core
  import tna_pkg::*;
#(
  parameter int unsigned COORD_WIDTH      = 32,
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic [COORD_WIDTH-1:0] vertex_c_z_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [NormalWidth-1:0] normal_x_o,
  output logic [NormalWidth-1:0] normal_y_o,
  output logic [NormalWidth-1:0] normal_z_o,
  output logic [AreaWidth-1:0]   tri_area_o,
  output logic                   degenerate_o,
  output logic                   area_saturated_o
);

  localparam int unsigned PW     = 2 * COORD_WIDTH + 2;
  localparam int unsigned SW     = 2 * PW + 2;
  localparam int unsigned QWidth = SW + 3 * PW + 4;
  localparam int unsigned QDepth = 16;
  localparam int unsigned CW     = $clog2(QDepth + 1);

  logic                          accept;
  logic [2:0][COORD_WIDTH-1:0]   va, vb, vc;
  logic                          f_valid, f_deg, q_deg;
  logic [2:0][PW-1:0]            f_mag, q_mag;
  logic [2:0]                    f_neg, q_neg;
  logic [SW-1:0]                 f_sq, q_sq;
  logic [QWidth-1:0]             q_din, q_dout;
  logic                          q_empty, q_take;
  logic [CW-1:0]                 cnt_q;

  assign va = {vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};
  assign vb = {vertex_b_z_i, vertex_b_y_i, vertex_b_x_i};
  assign vc = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i};

  // Credits cover the queue slots plus everything in flight in the front end,
  // which never stalls.
  assign full   = (cnt_q == CW'(QDepth));
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept != q_take) begin
      cnt_q <= accept ? cnt_q + CW'(1) : cnt_q - CW'(1);
    end
  end

  tna_front #(.CoordWidth(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .va_i    (va),
    .vb_i    (vb),
    .vc_i    (vc),
    .valid_o (f_valid),
    .mag_o   (f_mag),
    .neg_o   (f_neg),
    .sq_o    (f_sq),
    .deg_o   (f_deg)
  );

  assign q_din = {f_deg, f_neg, f_mag, f_sq};
  assign {q_deg, q_neg, q_mag, q_sq} = q_dout;

  tna_queue #(.Width(QWidth), .Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (q_din),
    .pop_i   (q_take),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  tna_back #(
    .CoordWidth     (COORD_WIDTH),
    .NormalFracBits (NORMAL_FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (!q_empty),
    .mag_i            (q_mag),
    .neg_i            (q_neg),
    .sq_i             (q_sq),
    .deg_i            (q_deg),
    .take_o           (q_take),
    .pop_i            (pop),
    .empty_o          (empty),
    .normal_x_o       (normal_x_o),
    .normal_y_o       (normal_y_o),
    .normal_z_o       (normal_z_o),
    .tri_area_o       (tri_area_o),
    .degenerate_o     (degenerate_o),
    .area_saturated_o (area_saturated_o)
  );

  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QDepth))
    else $error("credit count exceeds the queue depth");

endmodule

`default_nettype wire

/* src/tna_mul.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned multiplier
// Slices both operands, registers every partial product, then sums them.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_mul
  import tna_pkg::*;
#(
  parameter int unsigned W = 33
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int unsigned N  = (W + MulChunk - 1) / MulChunk;
  localparam int unsigned XW = N * MulChunk;

  logic [XW-1:0]           a_x, b_x;
  logic [2*MulChunk-1:0]   pp_q [N*N];
  logic [2*XW-1:0]         acc;
  logic [2*XW-1:0]         p_q;

  assign a_x = XW'(a_i);
  assign b_x = XW'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        pp_q[i*N+j] <= (2*MulChunk)'(a_x[i*MulChunk +: MulChunk])
                     * (2*MulChunk)'(b_x[j*MulChunk +: MulChunk]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        acc = acc + ((2*XW)'(pp_q[i*N+j]) << ((i + j) * MulChunk));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= acc;
  end

  assign p_o = p_q[2*W-1:0];

endmodule

`default_nettype wire

/* src/tna_front.sv */
// ----------------------------------------------------------------------------
// Triangle normal and area: front end
// Forms edges, the cross product, its magnitudes and the squared length.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_front #(
  parameter int unsigned CoordWidth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [2:0][CoordWidth-1:0]             va_i,
  input  logic [2:0][CoordWidth-1:0]             vb_i,
  input  logic [2:0][CoordWidth-1:0]             vc_i,
  output logic                                   valid_o,
  output logic [2:0][2*CoordWidth+1:0]           mag_o,
  output logic [2:0]                             neg_o,
  output logic [2*(2*CoordWidth+2)+1:0]          sq_o,
  output logic                                   deg_o
);

  localparam int unsigned EW = CoordWidth + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned XW = PW + 1;
  localparam int unsigned SW = 2 * PW + 2;

  // Operand index pairs of the edge products; each cross component is the difference of consecutive products.
  localparam int unsigned IdxA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int unsigned IdxB [6] = '{2, 1, 0, 2, 1, 0};

  logic [9:0]              v_q;
  logic [2:0][EW-1:0]      e1_q, e2_q, a1_q, a2_q;
  logic [2:0]              s1_q, s2_q;
  logic [5:0]              psg_d, psg3_q, psg4_q;
  logic [5:0][PW-1:0]      prod;
  logic [5:0][XW-1:0]      sp_q;
  logic [2:0][XW-1:0]      cr_q;
  logic [2:0][PW-1:0]      mag7_q, mag8_q, mag9_q, mag10_q;
  logic [2:0]              neg7_q, neg8_q, neg9_q, neg10_q;
  logic                    deg7_q, deg8_q, deg9_q, deg10_q;
  logic [2:0][2*PW-1:0]    sqp;
  logic [SW-1:0]           sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[8:0], valid_i};
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_edge_mul
    assign psg_d[g] = s1_q[IdxA[g]] ^ s2_q[IdxB[g]];
    tna_mul #(.W(EW)) u_mul (
      .clk_i (clk_i),
      .a_i   (a1_q[IdxA[g]]),
      .b_i   (a2_q[IdxB[g]]),
      .p_o   (prod[g])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_sq_mul
    tna_mul #(.W(PW)) u_sq (
      .clk_i (clk_i),
      .a_i   (mag7_q[c]),
      .b_i   (mag7_q[c]),
      .p_o   (sqp[c])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e1_q[k] <= {vb_i[k][CoordWidth-1], vb_i[k]} - {va_i[k][CoordWidth-1], va_i[k]};
      e2_q[k] <= {vc_i[k][CoordWidth-1], vc_i[k]} - {va_i[k][CoordWidth-1], va_i[k]};
      a1_q[k] <= e1_q[k][EW-1] ? (~e1_q[k] + EW'(1)) : e1_q[k];
      a2_q[k] <= e2_q[k][EW-1] ? (~e2_q[k] + EW'(1)) : e2_q[k];
      s1_q[k] <= e1_q[k][EW-1];
      s2_q[k] <= e2_q[k][EW-1];
    end
    psg3_q <= psg_d;
    psg4_q <= psg3_q;
    for (int g = 0; g < 6; g++) begin
      sp_q[g] <= psg4_q[g] ? (XW'(0) - XW'(prod[g])) : XW'(prod[g]);
    end
    for (int c = 0; c < 3; c++) begin
      cr_q[c]   <= sp_q[2*c] - sp_q[2*c+1];
      mag7_q[c] <= cr_q[c][XW-1] ? PW'(XW'(0) - cr_q[c]) : cr_q[c][PW-1:0];
      neg7_q[c] <= cr_q[c][XW-1];
    end
    deg7_q  <= (cr_q == '0);
    mag8_q  <= mag7_q;
    mag9_q  <= mag8_q;
    mag10_q <= mag9_q;
    neg8_q  <= neg7_q;
    neg9_q  <= neg8_q;
    neg10_q <= neg9_q;
    deg8_q  <= deg7_q;
    deg9_q  <= deg8_q;
    deg10_q <= deg9_q;
    sq_q    <= SW'(sqp[0]) + SW'(sqp[1]) + SW'(sqp[2]);
  end

  assign valid_o = v_q[9];
  assign mag_o   = mag10_q;
  assign neg_o   = neg10_q;
  assign sq_o    = sq_q;
  assign deg_o   = deg10_q;

endmodule

`default_nettype wire

/* src/tna_queue.sv */
// ----------------------------------------------------------------------------
// Triangle normal and area: decoupling queue
// Small show-ahead queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW:0]      wr_q, rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + (AW+1)'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[AW-1:0]] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q[AW-1:0]];
  assign empty_o = (wr_q == rd_q);

endmodule

`default_nettype wire

/* src/tna_back.sv */
// ----------------------------------------------------------------------------
// Triangle normal and area: back end
// Square root of the squared length, three normal divisions and the area.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_back
  import tna_pkg::*;
#(
  parameter int unsigned CoordWidth     = 32,
  parameter int unsigned NormalFracBits = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [2:0][2*CoordWidth+1:0]          mag_i,
  input  logic [2:0]                            neg_i,
  input  logic [2*(2*CoordWidth+2)+1:0]         sq_i,
  input  logic                                  deg_i,
  output logic                                  take_o,
  input  logic                                  pop_i,
  output logic                                  empty_o,
  output logic [NormalWidth-1:0]                normal_x_o,
  output logic [NormalWidth-1:0]                normal_y_o,
  output logic [NormalWidth-1:0]                normal_z_o,
  output logic [AreaWidth-1:0]                  tri_area_o,
  output logic                                  degenerate_o,
  output logic                                  area_saturated_o
);

  localparam int unsigned PW  = 2 * CoordWidth + 2;
  localparam int unsigned SW  = 2 * PW + 2;
  localparam int unsigned LW  = SW / 2;
  localparam int unsigned RW  = LW + 3;
  localparam int unsigned DW  = LW + 1;
  localparam int unsigned NF  = NormalFracBits;
  localparam int unsigned AXW = (LW > AreaShift + AreaWidth) ? LW
                                                              : AreaShift + AreaWidth + 1;

  logic en;

  // Square root stages
  logic [LW:0]                  sv_q;
  logic [LW:0][RW-1:0]          srem_q;
  logic [LW:0][LW-1:0]          sroot_q;
  logic [LW:0][SW-1:0]          ssrc_q;
  logic [LW:0][2:0][PW-1:0]     smag_q;
  logic [LW:0][2:0]             sneg_q;
  logic [LW:0]                  sdeg_q;
  logic [LW-1:0][RW-1:0]        sr_cur, sr_try, sr_rem;
  logic [LW-1:0][LW-1:0]        sr_root;
  logic [LW-1:0]                sr_ge;

  // Division stages
  logic [NF:0]                  dv_q;
  logic [NF:0][2:0][DW-1:0]     drem_q;
  logic [NF:0][2:0][NF:0]       dq_q;
  logic [NF:0][LW-1:0]          dden_q;
  logic [NF:0][2:0]             dneg_q;
  logic [NF:0]                  ddeg_q;
  logic [NF:0][2:0][DW-1:0]     dsh, drem_d;
  logic [NF:0][2:0][NF:0]       dqin, dq_d;
  logic [NF:0][LW-1:0]          dden_in;
  logic [NF:0][2:0]             dneg_in;
  logic [NF:0]                  ddeg_in;
  logic [NF:0][2:0]             dge;

  // Result register
  logic                         out_valid_q;
  logic [2:0][NormalWidth-1:0]  nrm_q, nrm_d;
  logic [AreaWidth-1:0]         area_q, area_d;
  logic                         deg_q, sat_q, sat_d;
  logic [AXW-1:0]               len_x, half_x;

  assign en     = !out_valid_q || pop_i;
  assign take_o = en && valid_i;

  always_comb begin
    for (int k = 0; k < LW; k++) begin
      sr_cur[k]  = {srem_q[k][RW-3:0], ssrc_q[k][SW-1 -: 2]};
      sr_try[k]  = RW'({sroot_q[k], 2'b01});
      sr_ge[k]   = sr_cur[k] >= sr_try[k];
      sr_rem[k]  = sr_ge[k] ? (sr_cur[k] - sr_try[k]) : sr_cur[k];
      sr_root[k] = {sroot_q[k][LW-2:0], sr_ge[k]};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsh[0][c]  = DW'(smag_q[LW][c]);
      dqin[0][c] = '0;
    end
    dden_in[0] = sroot_q[LW];
    dneg_in[0] = sneg_q[LW];
    ddeg_in[0] = sdeg_q[LW];
    for (int j = 1; j <= NF; j++) begin
      for (int c = 0; c < 3; c++) begin
        dsh[j][c]  = {drem_q[j-1][c][DW-2:0], 1'b0};
        dqin[j][c] = dq_q[j-1][c];
      end
      dden_in[j] = dden_q[j-1];
      dneg_in[j] = dneg_q[j-1];
      ddeg_in[j] = ddeg_q[j-1];
    end
    for (int j = 0; j <= NF; j++) begin
      for (int c = 0; c < 3; c++) begin
        dge[j][c]    = dsh[j][c] >= DW'(dden_in[j]);
        drem_d[j][c] = dge[j][c] ? (dsh[j][c] - DW'(dden_in[j])) : dsh[j][c];
        dq_d[j][c]   = {dqin[j][c][NF-1:0], dge[j][c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ddeg_q[NF]) begin
        nrm_d[c] = '0;
      end else if (dneg_q[NF][c]) begin
        nrm_d[c] = NormalWidth'(0) - NormalWidth'(dq_q[NF][c]);
      end else begin
        nrm_d[c] = NormalWidth'(dq_q[NF][c]);
      end
    end
    len_x  = AXW'(dden_q[NF]);
    half_x = len_x >> AreaShift;
    sat_d  = |half_x[AXW-1:AreaWidth];
    area_d = sat_d ? {AreaWidth{1'b1}} : half_x[AreaWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[LW-1:0], valid_i};
      dv_q        <= {dv_q[NF-1:0], sv_q[LW]};
      out_valid_q <= dv_q[NF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      ssrc_q[0]  <= sq_i;
      smag_q[0]  <= mag_i;
      sneg_q[0]  <= neg_i;
      sdeg_q[0]  <= deg_i;
      for (int k = 0; k < LW; k++) begin
        srem_q[k+1]  <= sr_rem[k];
        sroot_q[k+1] <= sr_root[k];
        ssrc_q[k+1]  <= {ssrc_q[k][SW-3:0], 2'b00};
        smag_q[k+1]  <= smag_q[k];
        sneg_q[k+1]  <= sneg_q[k];
        sdeg_q[k+1]  <= sdeg_q[k];
      end
      drem_q <= drem_d;
      dq_q   <= dq_d;
      dden_q <= dden_in;
      dneg_q <= dneg_in;
      ddeg_q <= ddeg_in;
      nrm_q  <= nrm_d;
      area_q <= ddeg_q[NF] ? '0 : area_d;
      deg_q  <= ddeg_q[NF];
      sat_q  <= !ddeg_q[NF] && sat_d;
    end
  end

  assign empty_o          = !out_valid_q;
  assign normal_x_o       = nrm_q[0];
  assign normal_y_o       = nrm_q[1];
  assign normal_z_o       = nrm_q[2];
  assign tri_area_o       = area_q;
  assign degenerate_o     = deg_q;
  assign area_saturated_o = sat_q;

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && deg_q |-> (nrm_q == '0) && (area_q == '0) && !sat_q)
    else $error("degenerate result carries a non-zero normal or area");

  a_sat_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sat_q |-> (area_q == {AreaWidth{1'b1}}))
    else $error("saturated area is not the maximum");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(nrm_q) && $stable(area_q))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

/* dv/tb_triangle_normal_and_area_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle normal and area core: testbench
// Sends triangles through the push side and takes results from the pop side.
// Each result is checked field by field against a predictor that computes the
// cross product, its integer square root and the divisions on wide vectors.
// Both sides idle at random. One phase holds pop off for a long time so that
// the core fills up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_normal_and_area_core
  import tna_pkg::*;
();

  localparam int unsigned CoordWidth    = 32;
  localparam int unsigned NormFracBits  = 30;
  localparam int          IdleLimit     = 3000;
  localparam int          DrainCycles   = 200;
  localparam int          RandomItems   = 1230;
  localparam int          PressureItems = 200;

  typedef struct {
    logic signed [CoordWidth-1:0] v [9];
  } triangle_t;

  typedef struct {
    logic [NormalWidth-1:0] nx, ny, nz;
    logic [AreaWidth-1:0]   area;
    logic                   degen;
    logic                   sat;
  } face_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [CoordWidth-1:0] vert [9];
  logic [NormalWidth-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [AreaWidth-1:0] tri_area_o;
  logic degenerate_o, area_saturated_o;

  face_t expected_faces [$];
  int    mismatches = 0;
  int    hold_off_cycles = 0;
  int    idle_count = 0;

  initial begin
    for (int i = 0; i < 9; i++) vert[i] = '0;
  end

  always #4 clk_i = ~clk_i;

  triangle_normal_and_area_core #(
    .COORD_WIDTH      (CoordWidth),
    .NORMAL_FRAC_BITS (NormFracBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .vertex_a_x_i     (vert[0]),
    .vertex_a_y_i     (vert[1]),
    .vertex_a_z_i     (vert[2]),
    .vertex_b_x_i     (vert[3]),
    .vertex_b_y_i     (vert[4]),
    .vertex_b_z_i     (vert[5]),
    .vertex_c_x_i     (vert[6]),
    .vertex_c_y_i     (vert[7]),
    .vertex_c_z_i     (vert[8]),
    .empty            (empty),
    .pop              (pop),
    .normal_x_o       (normal_x_o),
    .normal_y_o       (normal_y_o),
    .normal_z_o       (normal_z_o),
    .tri_area_o       (tri_area_o),
    .degenerate_o     (degenerate_o),
    .area_saturated_o (area_saturated_o)
  );

  // The predictor works on 256-bit words, wide enough that the squared
  // length of the cross product and every intermediate fit without loss.
  function automatic face_t face_of(triangle_t t);
    logic signed [255:0] p [9];
    logic signed [255:0] e1 [3];
    logic signed [255:0] e2 [3];
    logic signed [255:0] cr [3];
    logic [255:0] mag [3];
    logic [255:0] sq, len, cand, q, half;
    face_t f;
    for (int i = 0; i < 9; i++) p[i] = t.v[i];
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) mag[i] = cr[i][255] ? -cr[i] : cr[i];
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    f.nx = '0; f.ny = '0; f.nz = '0; f.area = '0; f.sat = 1'b0;
    if (sq == 0) begin
      f.degen = 1'b1;
      return f;
    end
    f.degen = 1'b0;
    // Integer square root, one result bit at a time from the top.
    len = '0;
    for (int b = 100; b >= 0; b--) begin
      cand = len | (256'd1 << b);
      if (cand * cand <= sq) len = cand;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << NormFracBits) / len;
      if (cr[i][255]) q = -q;
      case (i)
        0: f.nx = q[NormalWidth-1:0];
        1: f.ny = q[NormalWidth-1:0];
        default: f.nz = q[NormalWidth-1:0];
      endcase
    end
    half = len >> AreaShift;
    if (half >= (256'd1 << AreaWidth)) begin
      f.area = '1;
      f.sat  = 1'b1;
    end else begin
      f.area = half[AreaWidth-1:0];
    end
    return f;
  endfunction

  // Offers one triangle after a random gap, unless no_gap is set, and waits for its beat to be taken.
  task automatic send_triangle(triangle_t t, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) vert[i] <= t.v[i];
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    expected_faces.push_back(face_of(t));
  endtask

  task automatic idle_sender();
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (expected_faces.size() != 0) @(posedge clk_i);
  endtask

  function automatic triangle_t make_tri(logic signed [31:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz);
    triangle_t t;
    t.v[0] = ax; t.v[1] = ay; t.v[2] = az;
    t.v[3] = bx; t.v[4] = by; t.v[5] = bz;
    t.v[6] = cx; t.v[7] = cy; t.v[8] = cz;
    return t;
  endfunction

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 32'h0000_0040)) - 32'sh20;
    endcase
  endfunction

  // The result side: a random gap before each beat, preceded by a long hold-off when a
  // test asks for one, then pop stays high until a beat is taken.
  initial begin : result_side
    int gap;
    face_t want;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        want = expected_faces.pop_front();
        if (normal_x_o !== want.nx || normal_y_o !== want.ny ||
            normal_z_o !== want.nz || tri_area_o !== want.area ||
            degenerate_o !== want.degen || area_saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected n=(%h %h %h) area=%h deg=%b sat=%b", want.nx, want.ny,
                     want.nz, want.area, want.degen, want.sat);
            $display("actual   n=(%h %h %h) area=%h deg=%b sat=%b", normal_x_o,
                     normal_y_o, normal_z_o, tri_area_o, degenerate_o, area_saturated_o);
          end
        end
      end
    end
  end

  // Watchdog: a run without a beat on either side that reaches IdleLimit ends the test.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_count <= 0;
    end else if (rst_ni) begin
      idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Zero area, the smallest and largest coordinates, every sign and a
  // plain right triangle in each plane.
  task automatic test_directed();
    logic signed [31:0] mn, mx, one;
    mn = 32'sh8000_0000; mx = 32'sh7fff_ffff; one = 32'sh0001_0000;
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_triangle(make_tri(0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
    send_triangle(make_tri(0, 0, 0, one, 0, 0, 0, one, 0));
    send_triangle(make_tri(0, 0, 0, 0, one, 0, 0, 0, one));
    send_triangle(make_tri(0, 0, 0, 0, 0, one, one, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, one, 0, one, 0, 0));
    send_triangle(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    send_triangle(make_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx));
    send_triangle(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn));
    send_triangle(make_tri(mn, mn, mn, mx, mx, mx, mn, mx, mx));
    send_triangle(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
    send_triangle(make_tri(mn, 0, mx, 0, mx, mn, mx, mn, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1));
    send_triangle(make_tri(0, 0, 0, 1, 2, 3, 3, 2, 1));
    send_triangle(make_tri(-one, 0, 0, one, 0, 0, 0, mx, 0));
    send_triangle(make_tri(5, 7, -3, 5, 7, -3, 9, 1, 4));
    wait_drained();
  endtask

  task automatic test_random();
    triangle_t t;
    int kind, mode;
    for (int n = 0; n < RandomItems; n++) begin
      kind = $urandom_range(0, 9);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) t.v[i] = rand_coord(mode);
      if (kind == 0) begin
        // Two vertices coincide, so the cross product vanishes.
        for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i];
      end else if (kind == 1) begin
        // Third vertex on the line through the first two, unless the coordinates wrap.
        for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i] + 2 * (t.v[3+i] - t.v[i]);
      end
      send_triangle(t, n % 200 < 30);
    end
    wait_drained();
  endtask

  // The receiver holds off while triangles keep coming, so full must rise.
  // More triangles are sent than the pipelines and the queue can hold.
  task automatic test_backpressure();
    triangle_t t;
    hold_off_cycles = 400;
    for (int n = 0; n < PressureItems; n++) begin
      for (int i = 0; i < 9; i++) t.v[i] = rand_coord($urandom_range(0, 2));
      send_triangle(t, 1);
    end
    wait_drained();
  endtask

  initial begin : main
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_faces.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
